>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, ignored while reset is high.
`define DHTT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication assertion failed");

// Consequence in the cycle after the antecedent, checked during reset too.
`define DHTT_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`endif

>>> rtl/dhtt_pkg.sv
// ----------------------------------------------------------------------------
// Deadband heartbeat throttle package
// Types, codes and constants shared by the throttle table modules.
// ----------------------------------------------------------------------------
package dhtt_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLED      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_INTERVAL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORM_INTERVAL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRIT_INTERVAL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALE_LIMIT  = 3'd4;

   localparam logic [31:0] RST_LOW_INTERVAL  = 32'd3600000;
   localparam logic [31:0] RST_NORM_INTERVAL = 32'd300000;
   localparam logic [31:0] RST_CRIT_INTERVAL = 32'd30000;
   localparam logic [31:0] RST_STALE_LIMIT   = 32'd86400000;

   localparam logic [1:0] PRIO_NORMAL   = 2'd1;
   localparam logic [1:0] PRIO_CRITICAL = 2'd2;

   localparam logic CMD_SWEEP = 1'b1;

   typedef enum logic [2:0] {
      ST_DUE        = 3'd0,
      ST_SUPPRESSED = 3'd1,
      ST_NEW        = 3'd2,
      ST_FULL       = 3'd3,
      ST_NOT_READY  = 3'd4,
      ST_SWEEP_DONE = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      KIND_CHECK     = 2'd0,
      KIND_SWEEP     = 2'd1,
      KIND_NOT_READY = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [31:0]        key;
      logic signed [31:0] value;
      logic [30:0]        deadband;
      logic [31:0]        limit;
      logic [31:0]        now;
   } item_type;

   typedef struct packed {
      logic       publish;
      status_type status;
      logic [4:0] used;
      logic [4:0] removed;
   } rsp_type;

endpackage

>>> rtl/dhtt_front.sv
// ----------------------------------------------------------------------------
// Throttle front end
// Holds the configuration registers, accepts transactions and classifies
// them into not-ready, check and sweep work for the back end.
// ----------------------------------------------------------------------------
module dhtt_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               queue_full,
   input  logic                               req_command,
   input  logic [31:0]                        req_signal_key,
   input  logic signed [31:0]                 req_sample_value,
   input  logic [30:0]                        req_deadband,
   input  logic [1:0]                         req_priority_req,
   input  logic [31:0]                        req_now_ms,
   input  logic                               req_link_up,
   input  logic                               csr_we,
   input  logic [dhtt_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                        csr_wdata,
   output logic                               push,
   output dhtt_pkg::item_type                 item
);
   import dhtt_pkg::*;

   logic        enabled_ff,  enabled_in;
   logic [31:0] low_ff,      low_in;
   logic [31:0] norm_ff,     norm_in;
   logic [31:0] crit_ff,     crit_in;
   logic [31:0] stale_ff,    stale_in;
   logic [31:0] heartbeat;

   always_comb begin
      enabled_in = enabled_ff;
      low_in     = low_ff;
      norm_in    = norm_ff;
      crit_in    = crit_ff;
      stale_in   = stale_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLED:       enabled_in = csr_wdata[0];
            CSR_LOW_INTERVAL:  low_in     = csr_wdata;
            CSR_NORM_INTERVAL: norm_in    = csr_wdata;
            CSR_CRIT_INTERVAL: crit_in    = csr_wdata;
            CSR_STALE_LIMIT:   stale_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         low_ff     <= RST_LOW_INTERVAL;
         norm_ff    <= RST_NORM_INTERVAL;
         crit_ff    <= RST_CRIT_INTERVAL;
         stale_ff   <= RST_STALE_LIMIT;
      end else begin
         enabled_ff <= enabled_in;
         low_ff     <= low_in;
         norm_ff    <= norm_in;
         crit_ff    <= crit_in;
         stale_ff   <= stale_in;
      end
   end

   always_comb begin
      case (req_priority_req)
         PRIO_CRITICAL: heartbeat = crit_ff;
         PRIO_NORMAL:   heartbeat = norm_ff;
         default:       heartbeat = low_ff;
      endcase
   end

   always_comb begin
      push          = start && !queue_full;
      item.key      = req_signal_key;
      item.value    = req_sample_value;
      item.deadband = req_deadband;
      item.now      = req_now_ms;
      if (!enabled_ff || !req_link_up) begin
         item.kind  = KIND_NOT_READY;
         item.limit = heartbeat;
      end else if (req_command == CMD_SWEEP) begin
         item.kind  = KIND_SWEEP;
         item.limit = stale_ff;
      end else begin
         item.kind  = KIND_CHECK;
         item.limit = heartbeat;
      end
   end

endmodule

>>> rtl/dhtt_queue.sv
// ----------------------------------------------------------------------------
// Throttle work queue
// A short first-in first-out queue of classified transactions between the
// front end and the back end.
// ----------------------------------------------------------------------------
module dhtt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dhtt_pkg::item_type push_item,
   input  logic               pop,
   output dhtt_pkg::item_type pop_item,
   output logic               full,
   output logic               empty
);
   import dhtt_pkg::*;

   item_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff,  count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full     = count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/dhtt_back.sv
// ----------------------------------------------------------------------------
// Throttle back end
// Scans the slot table one entry a cycle, decides publish or suppress,
// inserts new keys, frees stale entries and registers each result.
// ----------------------------------------------------------------------------
module dhtt_back #(
   parameter int SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_empty,
   input  dhtt_pkg::item_type queue_item,
   output logic               pop,
   output logic               rsp_valid,
   output dhtt_pkg::rsp_type  rsp
);
   import dhtt_pkg::*;

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = $clog2(SLOTS + 1);
   localparam logic [CW-1:0]   SLOTS_C  = CW'(SLOTS);
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_DECIDE = 3'b100
   } state_type;

   state_type          state_ff,      state_in;
   item_type           cur_ff,        cur_in;
   logic [CW-1:0]      issue_ff,      issue_in;
   logic               pend_ff,       pend_in;
   logic [IDXW-1:0]    cmp_idx_ff,    cmp_idx_in;
   logic               free_found_ff, free_found_in;
   logic [IDXW-1:0]    free_idx_ff,   free_idx_in;
   logic [IDXW-1:0]    hit_idx_ff,    hit_idx_in;
   logic [CW-1:0]      removed_ff,    removed_in;
   logic [CW-1:0]      used_ff,       used_in;
   logic [SLOTS-1:0]   valid_ff,      valid_in;
   logic signed [33:0] diff_ff,       diff_in;
   logic [31:0]        elapsed_ff,    elapsed_in;
   logic               rsp_valid_ff,  rsp_valid_in;
   rsp_type            rsp_ff,        rsp_in;

   logic [31:0]        key_mem_ff  [SLOTS];
   logic [31:0]        val_mem_ff  [SLOTS];
   logic [31:0]        time_mem_ff [SLOTS];
   logic [31:0]        rd_key_ff;
   logic [31:0]        rd_val_ff;
   logic [31:0]        rd_time_ff;

   logic               mem_we;
   logic [IDXW-1:0]    mem_wa;
   logic               slot_hit;
   logic               slot_stale;
   logic               last_cmp;
   logic               trigger;
   logic signed [33:0] db_wide;
   logic [CW-1:0]      rem;
   logic [CW-1:0]      usd;
   logic               fnd;
   logic [IDXW-1:0]    fidx;

   function automatic rsp_type make_rsp(logic pub, status_type st,
                                        logic [CW-1:0] used_n,
                                        logic [CW-1:0] removed_n);
      rsp_type r;
      r.publish = pub;
      r.status  = st;
      r.used    = 5'(used_n);
      r.removed = 5'(removed_n);
      return r;
   endfunction

   assign slot_hit   = valid_ff[cmp_idx_ff] && (rd_key_ff == cur_ff.key);
   assign slot_stale = valid_ff[cmp_idx_ff] && ((cur_ff.now - rd_time_ff) > cur_ff.limit);
   assign last_cmp   = cmp_idx_ff == LAST_IDX;
   assign db_wide    = {3'b000, cur_ff.deadband};
   assign trigger    = (diff_ff >= db_wide) || (diff_ff <= -db_wide)
                       || (elapsed_ff >= cur_ff.limit);

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      cmp_idx_in    = issue_ff[IDXW-1:0];
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_idx_in    = hit_idx_ff;
      removed_in    = removed_ff;
      used_in       = used_ff;
      valid_in      = valid_ff;
      diff_in       = diff_ff;
      elapsed_in    = elapsed_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_wa        = hit_idx_ff;
      pop           = 1'b0;
      rem           = removed_ff;
      usd           = used_ff;
      fnd           = free_found_ff;
      fidx          = free_idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (!queue_empty) begin
               pop           = 1'b1;
               cur_in        = queue_item;
               issue_in      = '0;
               free_found_in = 1'b0;
               removed_in    = '0;
               if (queue_item.kind == KIND_NOT_READY) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = make_rsp(1'b0, ST_NOT_READY, used_ff, '0);
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue_ff != SLOTS_C) begin
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end
            if (pend_ff) begin
               if (cur_ff.kind == KIND_SWEEP) begin
                  if (slot_stale) begin
                     valid_in[cmp_idx_ff] = 1'b0;
                     rem = removed_ff + 1'b1;
                     if (used_ff != '0) begin
                        usd = used_ff - 1'b1;
                     end
                  end
                  removed_in = rem;
                  used_in    = usd;
                  if (last_cmp) begin
                     state_in     = S_IDLE;
                     rsp_valid_in = 1'b1;
                     rsp_in       = make_rsp(1'b0, ST_SWEEP_DONE, usd, rem);
                  end
               end else if (slot_hit) begin
                  hit_idx_in = cmp_idx_ff;
                  diff_in    = {{2{cur_ff.value[31]}}, cur_ff.value}
                               - {{2{rd_val_ff[31]}}, rd_val_ff};
                  elapsed_in = cur_ff.now - rd_time_ff;
                  state_in   = S_DECIDE;
               end else begin
                  if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
                     fnd  = 1'b1;
                     fidx = cmp_idx_ff;
                  end
                  free_found_in = fnd;
                  free_idx_in   = fidx;
                  if (last_cmp) begin
                     state_in     = S_IDLE;
                     rsp_valid_in = 1'b1;
                     if (fnd) begin
                        mem_we         = 1'b1;
                        mem_wa         = fidx;
                        valid_in[fidx] = 1'b1;
                        used_in        = used_ff + 1'b1;
                        rsp_in         = make_rsp(1'b1, ST_NEW, used_ff + 1'b1, '0);
                     end else begin
                        rsp_in = make_rsp(1'b1, ST_FULL, used_ff, '0);
                     end
                  end
               end
            end
         end
         S_DECIDE: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            if (trigger) begin
               mem_we = 1'b1;
               rsp_in = make_rsp(1'b1, ST_DUE, used_ff, '0);
            end else begin
               rsp_in = make_rsp(1'b0, ST_SUPPRESSED, used_ff, '0);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         used_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      issue_ff      <= issue_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_idx_ff    <= hit_idx_in;
      removed_ff    <= removed_in;
      diff_ff       <= diff_in;
      elapsed_ff    <= elapsed_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem_ff[mem_wa]  <= cur_ff.key;
         val_mem_ff[mem_wa]  <= cur_ff.value;
         time_mem_ff[mem_wa] <= cur_ff.now;
      end
      rd_key_ff  <= key_mem_ff[issue_ff[IDXW-1:0]];
      rd_val_ff  <= val_mem_ff[issue_ff[IDXW-1:0]];
      rd_time_ff <= time_mem_ff[issue_ff[IDXW-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> rtl/deadband_heartbeat_throttle_table.sv
// ----------------------------------------------------------------------------
// Deadband heartbeat throttle table
// Report-by-exception throttle with a bounded signal table, deadband and
// per-priority heartbeat intervals.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy rises only
// when both places of the two-entry work queue are taken. A sweep, or a check
// that misses, then scans the whole table in the back end through the single
// read port of the slot memories, one entry a cycle. A check that hits slot k
// stops the scan there. A not-ready transaction is answered from the idle
// state with no scan. Each result appears once on the rsp_ ports with
// rsp_valid high for one cycle and must be taken in that cycle. Results leave
// in the order the transactions were taken. Write the csr_ registers only
// while the block is idle.
module deadband_heartbeat_throttle_table #(
   parameter int SLOTS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_command,
   input  logic [31:0]                       req_signal_key,
   input  logic signed [31:0]                req_sample_value,
   input  logic [30:0]                       req_deadband,
   input  logic [1:0]                        req_priority_req,
   input  logic [31:0]                       req_now_ms,
   input  logic                              req_link_up,
   output logic                              rsp_valid,
   output logic                              rsp_publish,
   output logic [2:0]                        rsp_status,
   output logic [4:0]                        rsp_entries_used,
   output logic [4:0]                        rsp_entries_removed,
   input  logic                              csr_we,
   input  logic [dhtt_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [31:0]                       csr_wdata
);
   import dhtt_pkg::*;

   logic     push;
   item_type push_item;
   item_type pop_item;
   logic     pop;
   logic     queue_full;
   logic     queue_empty;
   rsp_type  rsp;

   dhtt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .queue_full       (queue_full),
      .req_command      (req_command),
      .req_signal_key   (req_signal_key),
      .req_sample_value (req_sample_value),
      .req_deadband     (req_deadband),
      .req_priority_req (req_priority_req),
      .req_now_ms       (req_now_ms),
      .req_link_up      (req_link_up),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .push             (push),
      .item             (push_item)
   );

   dhtt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   dhtt_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_item  (pop_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp         (rsp)
   );

   assign busy                = queue_full;
   assign rsp_publish         = rsp.publish;
   assign rsp_status          = rsp.status;
   assign rsp_entries_used    = rsp.used;
   assign rsp_entries_removed = rsp.removed;

endmodule

>>> rtl/dhtt_checker.sv
// ----------------------------------------------------------------------------
// Throttle port checker
// Watches the result and handshake ports of the throttle table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dhtt_checker (
   input logic       clock,
   input logic       reset,
   input logic       busy,
   input logic       rsp_valid,
   input logic       rsp_publish,
   input logic [2:0] rsp_status,
   input logic [4:0] rsp_entries_removed
);
   import dhtt_pkg::*;

   `DHTT_ASSERT_IMP(a_not_ready_silent, clock, reset, rsp_valid && rsp_status == ST_NOT_READY, !rsp_publish)
   `DHTT_ASSERT_IMP(a_removed_only_sweep, clock, reset, rsp_valid && rsp_status != ST_SWEEP_DONE, rsp_entries_removed == 5'd0)
   `DHTT_ASSERT_IMP(a_publish_codes, clock, reset, rsp_valid && rsp_publish, rsp_status == ST_DUE || rsp_status == ST_NEW || rsp_status == ST_FULL)
   `DHTT_ASSERT_NEXT(a_reset_quiet, clock, reset, !rsp_valid && !busy)

endmodule

bind deadband_heartbeat_throttle_table dhtt_checker u_dhtt_checker (
   .clock               (clock),
   .reset               (reset),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_publish         (rsp_publish),
   .rsp_status          (rsp_status),
   .rsp_entries_removed (rsp_entries_removed)
);

>>> sim/dhtt_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Throttle table scoreboard
// Behavioural model of the deadband heartbeat throttle table and an in-order
// checker for the responses it gives, one response per transaction.
// ----------------------------------------------------------------------------
package dhtt_tb_pkg;
   import dhtt_pkg::*;

   localparam int TABLE_SLOTS = 16;

   localparam logic CMD_CHECK = ~CMD_SWEEP;
   localparam logic [1:0] PRIO_LOW = 2'd0;
   localparam logic [1:0] PRIO_SPARE = 2'd3;

   typedef struct packed {
      logic               command;
      logic [31:0]        key;
      logic signed [31:0] value;
      logic [30:0]        deadband;
      logic [1:0]         prio;
      logic [31:0]        now_ms;
      logic               link_up;
   } throttle_request_type;

   class throttle_scoreboard;
      logic               enabled;
      logic [31:0]        low_interval;
      logic [31:0]        norm_interval;
      logic [31:0]        crit_interval;
      logic [31:0]        stale_limit;
      logic               slot_live [TABLE_SLOTS];
      logic [31:0]        slot_id [TABLE_SLOTS];
      logic signed [31:0] slot_value [TABLE_SLOTS];
      logic [31:0]        slot_stamp [TABLE_SLOTS];
      int unsigned        live_count;
      rsp_type            awaited [$];
      int unsigned        mismatches;
      int unsigned        responses;
      int unsigned        freed_total;
      int unsigned        status_count [6];

      function new();
         enabled = 1'b0;
         low_interval = RST_LOW_INTERVAL;
         norm_interval = RST_NORM_INTERVAL;
         crit_interval = RST_CRIT_INTERVAL;
         stale_limit = RST_STALE_LIMIT;
         foreach (slot_live[i]) begin
            slot_live[i] = 1'b0;
            slot_id[i] = '0;
            slot_value[i] = '0;
            slot_stamp[i] = '0;
         end
         live_count = 0;
         mismatches = 0;
         responses = 0;
         freed_total = 0;
         foreach (status_count[i]) status_count[i] = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] reg_index, logic [31:0] data);
         case (reg_index)
            CSR_ENABLED:       enabled = data[0];
            CSR_LOW_INTERVAL:  low_interval = data;
            CSR_NORM_INTERVAL: norm_interval = data;
            CSR_CRIT_INTERVAL: crit_interval = data;
            CSR_STALE_LIMIT:   stale_limit = data;
            default: ;
         endcase
      endfunction

      function void note_request(throttle_request_type req);
         rsp_type     res;
         logic [31:0] heartbeat;
         logic [31:0] elapsed;
         longint      diff;
         int          hit;
         int          free_slot;
         int unsigned freed;
         res.publish = 1'b0;
         res.status = ST_NOT_READY;
         res.removed = '0;
         freed = 0;
         if (enabled && req.link_up) begin
            if (req.command == CMD_SWEEP) begin
               res.status = ST_SWEEP_DONE;
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  elapsed = req.now_ms - slot_stamp[i];
                  if (slot_live[i] && elapsed > stale_limit) begin
                     slot_live[i] = 1'b0;
                     freed++;
                     if (live_count > 0) live_count--;
                  end
               end
               res.removed = freed[4:0];
               freed_total += freed;
            end else begin
               if (req.prio == PRIO_CRITICAL) heartbeat = crit_interval;
               else if (req.prio == PRIO_NORMAL) heartbeat = norm_interval;
               else heartbeat = low_interval;
               hit = -1;
               for (int i = 0; i < TABLE_SLOTS; i++)
                  if (hit < 0 && slot_live[i] && slot_id[i] == req.key) hit = i;
               if (hit >= 0) begin
                  diff = longint'(req.value) - longint'(slot_value[hit]);
                  if (diff < 0) diff = -diff;
                  elapsed = req.now_ms - slot_stamp[hit];
                  if (diff >= longint'(req.deadband) || elapsed >= heartbeat) begin
                     slot_value[hit] = req.value;
                     slot_stamp[hit] = req.now_ms;
                     res.publish = 1'b1;
                     res.status = ST_DUE;
                  end else begin
                     res.status = ST_SUPPRESSED;
                  end
               end else begin
                  free_slot = -1;
                  for (int i = 0; i < TABLE_SLOTS; i++)
                     if (free_slot < 0 && !slot_live[i]) free_slot = i;
                  res.publish = 1'b1;
                  if (free_slot >= 0) begin
                     slot_live[free_slot] = 1'b1;
                     slot_id[free_slot] = req.key;
                     slot_value[free_slot] = req.value;
                     slot_stamp[free_slot] = req.now_ms;
                     live_count++;
                     res.status = ST_NEW;
                  end else begin
                     res.status = ST_FULL;
                  end
               end
            end
         end
         res.used = live_count[4:0];
         status_count[int'(res.status)]++;
         awaited.insert(awaited.size(), res);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         responses++;
         if (awaited.size() == 0) begin
            $error("response with no transaction outstanding: status %0d", got.status);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (got.publish !== want.publish) begin
            $error("publish: expected %0d, got %0d", want.publish, got.publish);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.used !== want.used) begin
            $error("entries_used: expected %0d, got %0d", want.used, got.used);
            mismatches++;
         end
         if (got.removed !== want.removed) begin
            $error("entries_removed: expected %0d, got %0d", want.removed, got.removed);
            mismatches++;
         end
      endfunction

      function bit drained();
         return awaited.size() == 0;
      endfunction

      function void report(int unsigned settings);
         $display("Checked %0d responses: %0d due, %0d suppressed, %0d new, %0d table full,",
                  responses, status_count[ST_DUE], status_count[ST_SUPPRESSED],
                  status_count[ST_NEW], status_count[ST_FULL]);
         $display("%0d not ready, %0d sweeps freeing %0d slots, across %0d register settings.",
                  status_count[ST_NOT_READY], status_count[ST_SWEEP_DONE], freed_total,
                  settings);
      endfunction
   endclass

endpackage

>>> sim/deadband_heartbeat_throttle_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deadband heartbeat throttle table testbench
// Drives directed and random check and sweep transactions through several
// register settings, with random sender gaps, and compares every response
// against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module deadband_heartbeat_throttle_table_tb;
   import dhtt_pkg::*;
   import dhtt_tb_pkg::*;

   localparam int KEY_POOL = 22;
   localparam int SETTLE_CYCLES = 2 * (TABLE_SLOTS + 3) + 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam logic [31:0] KEY_A = 32'h8000_0001;
   localparam logic [31:0] KEY_B = 32'h7FFF_FFFE;
   localparam logic [31:0] FILL_BASE = 32'hC0DE_0000;
   localparam logic [31:0] T0 = 32'h0000_1000;
   localparam logic [31:0] T1 = T0 + 32'd30003;
   localparam logic [31:0] FILL_TIME = 32'h0000_0020;

   logic                             clock;
   logic                             reset;
   logic                             start;
   logic                             busy;
   logic                             req_command;
   logic [31:0]                      req_signal_key;
   logic signed [31:0]               req_sample_value;
   logic [30:0]                      req_deadband;
   logic [1:0]                       req_priority_req;
   logic [31:0]                      req_now_ms;
   logic                             req_link_up;
   logic                             rsp_valid;
   logic                             rsp_publish;
   logic [2:0]                       rsp_status;
   logic [4:0]                       rsp_entries_used;
   logic [4:0]                       rsp_entries_removed;
   logic                             csr_we;
   logic [CSR_INDEX_W-1:0]           csr_index;
   logic [31:0]                      csr_wdata;

   throttle_scoreboard throttle_model;
   logic [31:0]        key_pool [KEY_POOL];
   logic signed [31:0] pool_value [KEY_POOL];
   logic [31:0]        now_cursor;
   int unsigned        settings_applied;

   deadband_heartbeat_throttle_table #(
      .SLOTS(TABLE_SLOTS)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_signal_key      (req_signal_key),
      .req_sample_value    (req_sample_value),
      .req_deadband        (req_deadband),
      .req_priority_req    (req_priority_req),
      .req_now_ms          (req_now_ms),
      .req_link_up         (req_link_up),
      .rsp_valid           (rsp_valid),
      .rsp_publish         (rsp_publish),
      .rsp_status          (rsp_status),
      .rsp_entries_used    (rsp_entries_used),
      .rsp_entries_removed (rsp_entries_removed),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         throttle_model.check_response('{publish: rsp_publish,
                                         status: status_type'(rsp_status),
                                         used: rsp_entries_used,
                                         removed: rsp_entries_removed});
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) quiet = 0;
         else quiet++;
      end
      $display("** deadband_heartbeat_throttle_table: FAILED **");
      $finish;
   end

   function automatic throttle_request_type make_request(logic command, logic [31:0] key,
                                                         logic signed [31:0] value,
                                                         logic [30:0] deadband,
                                                         logic [1:0] prio, logic [31:0] now_ms,
                                                         logic link_up);
      throttle_request_type req;
      req.command = command;
      req.key = key;
      req.value = value;
      req.deadband = deadband;
      req.prio = prio;
      req.now_ms = now_ms;
      req.link_up = link_up;
      return req;
   endfunction

   function automatic throttle_request_type random_request();
      throttle_request_type req;
      int unsigned          pick;
      int                   delta;
      if ($urandom_range(0, 99) < 2) now_cursor = $urandom();
      else now_cursor = now_cursor + $urandom_range(0, 40);
      req.now_ms = now_cursor;
      req.link_up = ($urandom_range(0, 24) != 0);
      req.command = ($urandom_range(0, 11) == 0) ? CMD_SWEEP : CMD_CHECK;
      req.prio = 2'($urandom_range(0, 3));
      if ($urandom_range(0, 99) < 85) req.deadband = 31'($urandom_range(0, 64));
      else req.deadband = 31'($urandom());
      pick = $urandom_range(0, KEY_POOL - 1);
      if ($urandom_range(0, 99) < 85) begin
         delta = int'($urandom_range(0, 160)) - 80;
         if ($urandom_range(0, 14) == 0) pool_value[pick] = $urandom();
         else pool_value[pick] = pool_value[pick] + delta;
         req.key = key_pool[pick];
         req.value = pool_value[pick];
      end else begin
         req.key = $urandom();
         req.value = $urandom();
      end
      return req;
   endfunction

   task automatic send_request(throttle_request_type req);
      req_command <= req.command;
      req_signal_key <= req.key;
      req_sample_value <= req.value;
      req_deadband <= req.deadband;
      req_priority_req <= req.prio;
      req_now_ms <= req.now_ms;
      req_link_up <= req.link_up;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      throttle_model.note_request(req);
   endtask

   task automatic hold_off(int unsigned cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (!throttle_model.drained()) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] reg_index, logic [31:0] data);
      csr_we <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= data;
      @(posedge clock);
      throttle_model.write_reg(reg_index, data);
   endtask

   task automatic apply_settings(logic enable, logic [31:0] low, logic [31:0] norm,
                                 logic [31:0] crit, logic [31:0] stale);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write(CSR_ENABLED, {31'd0, enable});
      csr_write(CSR_LOW_INTERVAL, low);
      csr_write(CSR_NORM_INTERVAL, norm);
      csr_write(CSR_CRIT_INTERVAL, crit);
      csr_write(CSR_STALE_LIMIT, stale);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   task automatic run_random(int unsigned count, int unsigned gap_pct);
      int unsigned gap;
      for (int unsigned n = 0; n < count; n++) begin
         gap = 0;
         while ($urandom_range(0, 99) < gap_pct) gap++;
         hold_off(gap);
         if (n == count / 2 || $urandom_range(0, 199) == 0) wait_drained();
         send_request(random_request());
      end
   endtask

   initial begin
      throttle_model = new();
      settings_applied = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_command <= CMD_CHECK;
      req_signal_key <= '0;
      req_sample_value <= '0;
      req_deadband <= '0;
      req_priority_req <= PRIO_LOW;
      req_now_ms <= '0;
      req_link_up <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= CSR_ENABLED;
      csr_wdata <= '0;
      foreach (key_pool[i]) begin
         key_pool[i] = $urandom();
         pool_value[i] = $urandom();
      end
      now_cursor = $urandom();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Still disabled after reset, so every transaction is answered as not ready.
      send_request(make_request(CMD_CHECK, KEY_A, '0, '0, PRIO_NORMAL, T0, 1'b1));
      apply_settings(1'b1, RST_LOW_INTERVAL, RST_NORM_INTERVAL, RST_CRIT_INTERVAL,
                     RST_STALE_LIMIT);
      send_request(make_request(CMD_CHECK, KEY_A, '0, '0, PRIO_NORMAL, T0, 1'b0));
      send_request(make_request(CMD_SWEEP, KEY_A, '0, '0, PRIO_LOW, T0, 1'b0));
      send_request(make_request(CMD_CHECK, KEY_A, 32'sh8000_0000, '0, PRIO_LOW, T0, 1'b1));
      send_request(make_request(CMD_CHECK, KEY_A, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
                                PRIO_NORMAL, T0 + 32'd1, 1'b1));
      send_request(make_request(CMD_CHECK, KEY_A, 32'sh7FFF_FFEF, 31'h11, PRIO_CRITICAL,
                                T0 + 32'd2, 1'b1));
      send_request(make_request(CMD_CHECK, KEY_A, 32'sh7FFF_FFEF, 31'h10, PRIO_CRITICAL,
                                T0 + 32'd3, 1'b1));
      send_request(make_request(CMD_CHECK, KEY_A, 32'sh7FFF_FFEF, 31'h1, PRIO_CRITICAL,
                                T0 + 32'd30002, 1'b1));
      send_request(make_request(CMD_CHECK, KEY_A, 32'sh7FFF_FFEF, 31'h1, PRIO_CRITICAL,
                                T1, 1'b1));
      send_request(make_request(CMD_CHECK, KEY_A, 32'sh7FFF_FFEF, 31'h1, PRIO_SPARE,
                                T1 + RST_LOW_INTERVAL, 1'b1));
      send_request(make_request(CMD_CHECK, KEY_B, 32'sh0001_0000, 31'h100, PRIO_NORMAL,
                                32'hFFFF_FFF0, 1'b1));
      send_request(make_request(CMD_CHECK, KEY_B, 32'sh0001_0000, 31'h7FFF_FFFF,
                                PRIO_CRITICAL, 32'h0000_0010, 1'b1));
      for (int i = 0; i < TABLE_SLOTS - 2; i++)
         send_request(make_request(CMD_CHECK, FILL_BASE | i, 32'(i << 16), 31'h100,
                                   PRIO_NORMAL, FILL_TIME, 1'b1));
      send_request(make_request(CMD_CHECK, FILL_BASE | 32'hFF, '0, 31'h100, PRIO_NORMAL,
                                FILL_TIME, 1'b1));
      // Entries aged exactly the stale limit survive; only the older one goes.
      send_request(make_request(CMD_SWEEP, '0, '0, '0, PRIO_LOW,
                                FILL_TIME + RST_STALE_LIMIT, 1'b1));

      apply_settings(1'b1, 32'd200, 32'd60, 32'd15, 32'd400);
      run_random(230, 17);
      apply_settings(1'b1, 32'd0, 32'd0, 32'd0, 32'd0);
      run_random(200, 17);
      apply_settings(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_random(240, 47);
      apply_settings(1'b0, 32'd1000, 32'd300, 32'd40, 32'd2000);
      run_random(40, 47);
      apply_settings(1'b1, 32'd1000, 32'd300, 32'd40, 32'd2000);
      run_random(260, 47);
      apply_settings(1'b1, $urandom_range(0, 400), $urandom_range(0, 120),
                     $urandom_range(0, 30), $urandom_range(0, 800));
      run_random(260, 0);
      apply_settings(1'b1, 32'd5000, 32'd800, 32'd25, 32'd3000);
      run_random(220, 0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      throttle_model.report(settings_applied);
      if (throttle_model.mismatches == 0)
         $display("** deadband_heartbeat_throttle_table: PASSED **");
      else
         $display("** deadband_heartbeat_throttle_table: FAILED **");
      $finish;
   end

endmodule
